### rtl/core/marching_squares_triangulator_core_macros.svh
// assertion macros for the marching squares triangulator core
// used by the top level only
`ifndef MARCHING_SQUARES_TRIANGULATOR_CORE_MACROS_SVH
`define MARCHING_SQUARES_TRIANGULATOR_CORE_MACROS_SVH
`ifndef NO_ASSERTIONS
`define MST_ASSERT_IMPL(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
`define MST_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define MST_ASSERT_IMPL(label, clk, rst_n, prop)
`define MST_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

### rtl/core/mst_pkg.sv
// shared types, constants and tables of the marching squares triangulator
// no dependencies
`timescale 1ns / 1ps
package mst_pkg;
  localparam int MaxRows = 1024;
  localparam int MaxCols = 1024;
  localparam int RowW = $clog2(MaxRows);
  localparam int ColW = $clog2(MaxCols);
  localparam logic [16:0] OneQ14 = 17'd16384;
  localparam int CoordW = 29;

  typedef enum logic [2:0] {
    CFG_ROWS = 3'd0, CFG_COLS = 3'd1, CFG_CW = 3'd2, CFG_CH = 3'd3, CFG_ISO = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic load;
    logic div_start;
    logic [1:0] div_edge;
    logic emit_next;
  } ctl_t;

  typedef struct packed {
    logic emit;
    logic div_busy;
    logic div_done;
    logic last;
    logic [3:0] code;
    logic [3:0] count;
  } sts_t;

  function automatic logic [3:0] tri_count(input logic [3:0] c);
    logic [3:0] r;
    unique case (c)
      4'd0: r = 4'd0; 4'd1: r = 4'd3; 4'd2: r = 4'd3; 4'd3: r = 4'd6;
      4'd4: r = 4'd3; 4'd5: r = 4'd12; 4'd6: r = 4'd6; 4'd7: r = 4'd9;
      4'd8: r = 4'd3; 4'd9: r = 4'd6; 4'd10: r = 4'd12; 4'd11: r = 4'd9;
      4'd12: r = 4'd6; 4'd13: r = 4'd9; 4'd14: r = 4'd9;
      default: r = 4'd6;
    endcase
    return r;
  endfunction

  function automatic logic [47:0] tri_row(input logic [3:0] c);
    logic [47:0] r;
    unique case (c)
      4'd1: r = {36'd0, 4'd5, 4'd4, 4'd6};
      4'd2: r = {36'd0, 4'd2, 4'd4, 4'd3};
      4'd3: r = {24'd0, 4'd5, 4'd3, 4'd2, 4'd5, 4'd6, 4'd2};
      4'd4: r = {36'd0, 4'd0, 4'd2, 4'd1};
      4'd5: r = {4'd2, 4'd0, 4'd1, 4'd0, 4'd2, 4'd4, 4'd4, 4'd0, 4'd6, 4'd4, 4'd6, 4'd5};
      4'd6: r = {24'd0, 4'd4, 4'd3, 4'd1, 4'd1, 4'd4, 4'd0};
      4'd7: r = {12'd0, 4'd3, 4'd1, 4'd0, 4'd3, 4'd0, 4'd6, 4'd3, 4'd5, 4'd6};
      4'd8: r = {36'd0, 4'd0, 4'd6, 4'd7};
      4'd9: r = {24'd0, 4'd4, 4'd5, 4'd7, 4'd7, 4'd4, 4'd0};
      4'd10: r = {4'd2, 4'd4, 4'd3, 4'd0, 4'd2, 4'd4, 4'd4, 4'd6, 4'd0, 4'd6, 4'd0, 4'd7};
      4'd11: r = {12'd0, 4'd3, 4'd2, 4'd5, 4'd2, 4'd0, 4'd5, 4'd0, 4'd5, 4'd7};
      4'd12: r = {24'd0, 4'd6, 4'd1, 4'd7, 4'd1, 4'd6, 4'd2};
      4'd13: r = {12'd0, 4'd7, 4'd5, 4'd4, 4'd4, 4'd2, 4'd7, 4'd7, 4'd2, 4'd1};
      4'd14: r = {12'd0, 4'd3, 4'd1, 4'd4, 4'd4, 4'd6, 4'd1, 4'd6, 4'd7, 4'd1};
      4'd15: r = {24'd0, 4'd7, 4'd5, 4'd3, 4'd3, 4'd7, 4'd1};
      default: r = 48'd0;
    endcase
    return r;
  endfunction

  function automatic logic [15:0] sat16(input logic signed [CoordW-1:0] v);
    logic [15:0] r;
    if (v > 32767) r = 16'h7fff;
    else if (v < -32768) r = 16'h8000;
    else r = v[15:0];
    return r;
  endfunction
endpackage

### rtl/core/mst_divider.sv
// restoring divider, one quotient bit per cycle, rounds half up
// depends on mst_pkg
`timescale 1ns / 1ps
module mst_divider (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [32:0] num_i,
  input  logic [16:0] den_i,
  output logic        busy_o,
  output logic        done_o,
  output logic [16:0] quo_o
);
  import mst_pkg::*;
  // numerator 2*num+den fits 34 bits, den*2 fits 18 bits; quotient <= step
  logic [33:0] n_q, n_d;
  logic [17:0] d_q, d_d;
  logic [18:0] rem_q, rem_d;
  logic [5:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d, done_q, done_d;
  logic [18:0] sh;

  always_comb begin
    n_d = n_q; d_d = d_q; rem_d = rem_q; cnt_d = cnt_q;
    busy_d = busy_q; done_d = 1'b0;
    sh = {rem_q[17:0], n_q[33]};
    if (start_i) begin
      n_d = {num_i, 1'b0} + {16'd0, den_i};
      d_d = {den_i, 1'b0};
      rem_d = '0;
      cnt_d = 6'd34;
      busy_d = 1'b1;
    end else if (busy_q) begin
      n_d = {n_q[32:0], 1'b0};
      if (sh >= {1'b0, d_q}) begin
        rem_d = sh - {1'b0, d_q};
        n_d[0] = 1'b1;
      end else begin
        rem_d = sh;
      end
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; done_q <= 1'b0; cnt_q <= '0;
    end else begin
      busy_q <= busy_d; done_q <= done_d; cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q <= n_d; d_q <= d_d; rem_q <= rem_d;
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quo_o  = n_q[16:0];
endmodule

### rtl/core/mst_datapath.sv
// line store, counters, corner classification, edge placement and vertex output
// depends on mst_pkg and mst_divider
`timescale 1ns / 1ps
module mst_datapath (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [2:0]        cfg_idx_i,
  input  logic [15:0]       cfg_data_i,
  input  logic [15:0]       field_value_i,
  input  mst_pkg::ctl_t     ctl_i,
  output mst_pkg::sts_t     sts_o,
  output logic signed [15:0] vertex_x_o,
  output logic signed [15:0] vertex_y_o,
  output logic              last_vertex_o
);
  import mst_pkg::*;

  logic [15:0] mem_q [MaxRows];
  logic [15:0] nw_rd_q;
  logic [10:0] rows_cfg_q, cols_cfg_q;
  logic [15:0] cw_q, ch_q, iso_q;
  logic [RowW-1:0] row_q;
  logic [ColW-1:0] col_q;
  logic [15:0] bcur_q, bprev_q;
  logic [15:0] ne_q, nw_q, sw_q, se_q;
  logic [3:0]  code_q;
  logic        emit_q;
  logic signed [CoordW-1:0] px_q [8];
  logic signed [CoordW-1:0] py_q [8];
  logic [3:0]  k_q;
  logic [1:0]  edge_q;
  logic [10:0] rows_eff, cols_eff;
  logic [3:0]  code_d;
  logic signed [CoordW-1:0] x_w, y_w;
  logic [16:0] fa, fb, st;
  logic signed [17:0] num_s, den_s;
  logic [32:0] div_num;
  logic [16:0] div_den, quo;
  logic div_busy, div_done;
  logic [47:0] row_ids;
  logic [2:0]  vid;
  logic [3:0]  cnt;

  always_comb begin
    rows_eff = rows_cfg_q < 11'd2 ? 11'd2 : (rows_cfg_q > 11'(MaxRows) ? 11'(MaxRows) : rows_cfg_q);
    cols_eff = cols_cfg_q < 11'd2 ? 11'd2 : (cols_cfg_q > 11'(MaxCols) ? 11'(MaxCols) : cols_cfg_q);
  end

  // line store: read runs ahead with the current row index
  always_ff @(posedge clk_i) begin
    if (ctl_i.load) mem_q[row_q] <= field_value_i;
    nw_rd_q <= mem_q[row_q];
  end

  always_comb begin
    code_d = {nw_rd_q >= iso_q, field_value_i >= iso_q, bcur_q >= iso_q, bprev_q >= iso_q};
    x_w = signed'(CoordW'(col_q) * CoordW'(cw_q)) - signed'(CoordW'(OneQ14));
    y_w = signed'(CoordW'(row_q) * CoordW'(ch_q)) - signed'(CoordW'(OneQ14));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_cfg_q <= 11'd64; cols_cfg_q <= 11'd64;
      cw_q <= 16'd520; ch_q <= 16'd520; iso_q <= 16'd256;
      row_q <= '0; col_q <= '0; bcur_q <= '0; bprev_q <= '0;
      emit_q <= 1'b0; code_q <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_ROWS: rows_cfg_q <= cfg_data_i[10:0];
          CFG_COLS: cols_cfg_q <= cfg_data_i[10:0];
          CFG_CW:   cw_q <= cfg_data_i;
          CFG_CH:   ch_q <= cfg_data_i;
          CFG_ISO:  iso_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (ctl_i.load) begin
        emit_q <= (col_q != '0) && (row_q != '0);
        code_q <= code_d;
        bcur_q <= field_value_i;
        bprev_q <= nw_rd_q;
        if ({1'b0, row_q} + 11'd1 >= rows_eff) begin
          row_q <= '0;
          if ({1'b0, col_q} + 11'd1 >= cols_eff) col_q <= '0;
          else col_q <= col_q + 1'b1;
        end else begin
          row_q <= row_q + 1'b1;
        end
      end
    end
  end

  // edge select: 0 south, 1 west, 2 east, 3 north
  always_comb begin
    unique case (ctl_i.div_edge)
      2'd0: begin fa = {1'b0, sw_q}; fb = {1'b0, se_q}; st = {1'b0, cw_q}; end
      2'd1: begin fa = {1'b0, sw_q}; fb = {1'b0, nw_q}; st = {1'b0, ch_q}; end
      2'd2: begin fa = {1'b0, se_q}; fb = {1'b0, ne_q}; st = {1'b0, ch_q}; end
      default: begin fa = {1'b0, nw_q}; fb = {1'b0, ne_q}; st = {1'b0, cw_q}; end
    endcase
    num_s = signed'({1'b0, iso_q}) - signed'({1'b0, fa});
    den_s = signed'({1'b0, fb}) - signed'({1'b0, fa});
    if (den_s < 0) begin
      den_s = -den_s;
      num_s = -num_s;
    end
    if (num_s < 0) num_s = '0;
    div_num = 33'(num_s[16:0]) * 33'(st);
    div_den = den_s[16:0];
  end

  mst_divider u_div (
    .clk_i, .rst_ni, .start_i(ctl_i.div_start), .num_i(div_num), .den_i(div_den),
    .busy_o(div_busy), .done_o(div_done), .quo_o(quo)
  );

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      ne_q <= field_value_i; nw_q <= nw_rd_q; sw_q <= bprev_q; se_q <= bcur_q;
      px_q[0] <= x_w - CoordW'(cw_q >> 1); py_q[0] <= y_w;
      px_q[1] <= x_w;                      py_q[1] <= y_w;
      px_q[2] <= x_w;                      py_q[2] <= y_w - CoordW'(ch_q >> 1);
      px_q[3] <= x_w;                      py_q[3] <= y_w - CoordW'(ch_q);
      px_q[4] <= x_w - CoordW'(cw_q >> 1); py_q[4] <= y_w - CoordW'(ch_q);
      px_q[5] <= x_w - CoordW'(cw_q);      py_q[5] <= y_w - CoordW'(ch_q);
      px_q[6] <= x_w - CoordW'(cw_q);      py_q[6] <= y_w - CoordW'(ch_q >> 1);
      px_q[7] <= x_w - CoordW'(cw_q);      py_q[7] <= y_w;
    end
    if (ctl_i.div_start) edge_q <= ctl_i.div_edge;
    if (div_done) begin
      unique case (edge_q)
        2'd0: px_q[4] <= px_q[5] + CoordW'(quo);
        2'd1: py_q[6] <= py_q[5] + CoordW'(quo);
        2'd2: py_q[2] <= py_q[3] + CoordW'(quo);
        default: px_q[0] <= px_q[7] + CoordW'(quo);
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) k_q <= '0;
    else if (ctl_i.load) k_q <= '0;
    else if (ctl_i.emit_next) k_q <= k_q + 4'd1;
  end

  always_comb begin
    row_ids = tri_row(code_q);
    vid = row_ids[k_q*4 +: 3];
    cnt = tri_count(code_q);
  end

  assign vertex_x_o    = sat16(px_q[vid]);
  assign vertex_y_o    = sat16(py_q[vid]);
  assign last_vertex_o = (k_q == cnt - 4'd1);

  assign sts_o.emit     = emit_q;
  assign sts_o.div_busy = div_busy;
  assign sts_o.div_done = div_done;
  assign sts_o.last     = last_vertex_o;
  assign sts_o.code     = code_q;
  assign sts_o.count    = cnt;
endmodule

### rtl/core/mst_controller.sv
// sequencer: accept a sample, run crossed-edge divisions, stream vertices
// depends on mst_pkg
`timescale 1ns / 1ps
module mst_controller (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output mst_pkg::ctl_t ctl_o,
  input  mst_pkg::sts_t sts_i
);
  import mst_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001, S_PREP = 5'b00010, S_DIV = 5'b00100,
    S_WAIT = 5'b01000, S_EMIT = 5'b10000
  } state_e;

  state_e state_q, state_d;
  logic [1:0] edge_q, edge_d;
  logic crossed;

  always_comb begin
    unique case (edge_q)
      2'd0: crossed = sts_i.code[0] != sts_i.code[1];
      2'd1: crossed = sts_i.code[0] != sts_i.code[3];
      2'd2: crossed = sts_i.code[1] != sts_i.code[2];
      default: crossed = sts_i.code[3] != sts_i.code[2];
    endcase
  end

  always_comb begin
    state_d = state_q; edge_d = edge_q;
    ctl_o = '0;
    ctl_o.div_edge = edge_q;
    in_ready_o = 1'b0; out_valid_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          ctl_o.load = 1'b1;
          state_d = S_PREP;
        end
      end
      S_PREP: begin
        edge_d = 2'd0;
        state_d = (sts_i.emit && sts_i.count != 4'd0) ? S_DIV : S_IDLE;
      end
      S_DIV: begin
        if (crossed) begin
          ctl_o.div_start = 1'b1;
          state_d = S_WAIT;
        end else if (edge_q == 2'd3) begin
          state_d = S_EMIT;
        end else begin
          edge_d = edge_q + 2'd1;
        end
      end
      S_WAIT: begin
        if (sts_i.div_done) begin
          if (edge_q == 2'd3) state_d = S_EMIT;
          else begin
            edge_d = edge_q + 2'd1;
            state_d = S_DIV;
          end
        end
      end
      S_EMIT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          ctl_o.emit_next = 1'b1;
          if (sts_i.last) state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; edge_q <= '0;
    end else begin
      state_q <= state_d; edge_q <= edge_d;
    end
  end
endmodule

### rtl/core/marching_squares_triangulator_core.sv
// marching squares triangulator core: one field sample per input beat
// sequence: accept and classify a sample (S_IDLE, S_PREP); a cell with vertices then checks each
// edge in turn and runs a division per crossed edge (0, 2 or 4), then one output beat per vertex
// a new sample is accepted only once the previous cell is done and its vertices have been sent
// reset: asynchronous active low, counters cleared, configuration registers to defaults,
// line store contents undefined until written
`timescale 1ns / 1ps
`include "marching_squares_triangulator_core_macros.svh"
module marching_squares_triangulator_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [2:0]        cfg_idx_i,
  input  logic [15:0]       cfg_data_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [15:0]       field_value_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic signed [15:0] vertex_x_o,
  output logic signed [15:0] vertex_y_o,
  output logic              last_vertex_o
);
  import mst_pkg::*;

  ctl_t ctl;
  sts_t sts;

  mst_controller u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i,
    .ctl_o(ctl), .sts_i(sts)
  );

  mst_datapath u_dp (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i, .field_value_i,
    .ctl_i(ctl), .sts_o(sts), .vertex_x_o, .vertex_y_o, .last_vertex_o
  );

  `MST_ASSERT_IMPL(a_no_accept_while_out, clk_i, rst_ni, !(in_ready_o && out_valid_o))
  `MST_ASSERT_NEXT(a_div_start_busy, clk_i, rst_ni, ctl.div_start, sts.div_busy)
  `MST_ASSERT_IMPL(a_no_out_while_div, clk_i, rst_ni, !(out_valid_o && sts.div_busy))
endmodule
